[src/i2cm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C master byte engine: command codes,
// engine modes, and the tick item and result formats.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] SS_PHASES    = 3'd5;
  localparam logic [2:0] WR_BIT_PHASES = 3'd3;
  localparam logic [2:0] WR_ACK_PHASES = 3'd2;
  localparam logic [2:0] RD_BIT_PHASES = 3'd2;
  localparam logic [2:0] RD_ACK_PHASES = 3'd3;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_START = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_WRITE = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t       kind;
    logic [7:0]  wr_byte;
    logic        send_nack;
    logic        sda_in;
  } tick_item_t;

  typedef struct packed {
    logic        ack_status;
    logic [7:0]  rd_byte;
    logic        done_res;
    logic        busy_res;
    logic        sda_level;
    logic        scl_level;
  } result_t;

endpackage
`default_nettype wire

[src/i2cm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: accepts tick beats and classifies the command field into an
// engine mode, pushing the decoded item into the tick queue.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,
  input  wire logic [2:0]            in_tuser,
  output logic                       q_push,
  output i2cm_pkg::tick_item_t       q_item,
  input  wire logic                  q_full
);
  import i2cm_pkg::*;

  mode_t kind;

  always_comb begin
    unique case (in_tuser)
      CMD_START: kind = MODE_START;
      CMD_STOP:  kind = MODE_STOP;
      CMD_WRITE: kind = MODE_WRITE;
      CMD_READ:  kind = MODE_READ;
      default:   kind = MODE_IDLE;
    endcase
  end

  assign in_tready         = ~q_full;
  assign q_push            = in_tvalid & ~q_full;
  assign q_item.kind       = kind;
  assign q_item.wr_byte    = in_tdata[7:0];
  assign q_item.send_nack  = in_tdata[8];
  assign q_item.sda_in     = in_tdata[9];

endmodule
`default_nettype wire

[src/i2cm_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_queue
// Short FIFO of decoded tick items between the front and the engine.
// ----------------------------------------------------------------------------
module i2cm_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire i2cm_pkg::tick_item_t  push_item,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       nonempty,
  output i2cm_pkg::tick_item_t       head_item
);
  import i2cm_pkg::*;

  tick_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign nonempty  = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ((wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1)
                      : wr_ptr_r;
    rd_ptr_nxt = pop  ? ((rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1)
                      : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[src/i2cm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_back
// Bus engine: takes one tick item per cycle from the queue, when one is
// queued and the result register is free or being read, steps the
// start/stop/write/read phase sequencer and registers the line levels and status as one result beat.
// ----------------------------------------------------------------------------
module i2cm_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [7:0]            cfg_wdata,
  input  wire logic                  q_nonempty,
  input  wire i2cm_pkg::tick_item_t  q_item,
  output logic                       q_pop,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output i2cm_pkg::result_t          res
);
  import i2cm_pkg::*;

  logic [7:0]  phase_len_r;
  mode_t       mode_r, mode_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_r, ack_nxt;
  logic        nack_r;
  logic [7:0]  last_r, last_nxt;
  logic        res_valid_r;
  result_t     res_r;

  logic        step, start_cmd, active, phase_end, fin, done;
  mode_t       cur_mode;
  logic [2:0]  cur_phase, ph_inc, ph_adv;
  logic [3:0]  cur_bit, bit_adv;
  logic [7:0]  cur_tick, tick_inc, plen, cur_shift;
  logic        cur_nack, in_bits;

  assign step      = q_nonempty & (~res_valid_r | res_ready);
  assign q_pop     = step;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign start_cmd = (mode_r == MODE_IDLE) & (q_item.kind != MODE_IDLE);
  assign cur_mode  = start_cmd ? q_item.kind : mode_r;
  assign cur_phase = start_cmd ? 3'd0 : phase_r;
  assign cur_bit   = start_cmd ? 4'd0 : bit_r;
  assign cur_tick  = start_cmd ? 8'd0 : tick_r;
  assign cur_shift = start_cmd ? ((q_item.kind == MODE_WRITE) ? q_item.wr_byte : 8'd0)
                               : shift_r;
  assign cur_nack  = start_cmd ? q_item.send_nack : nack_r;
  assign active    = (cur_mode != MODE_IDLE);
  assign in_bits   = ~cur_bit[3];

  assign plen      = (phase_len_r == 8'd0) ? 8'd1 : phase_len_r;
  assign tick_inc  = cur_tick + 8'd1;
  assign phase_end = (tick_inc >= plen);
  assign ph_inc    = cur_phase + 3'd1;
  assign done      = active & phase_end & fin;

  // phase sequencing
  always_comb begin
    fin     = 1'b0;
    ph_adv  = ph_inc;
    bit_adv = cur_bit;
    unique case (cur_mode)
      MODE_START, MODE_STOP: begin
        fin = (ph_inc >= SS_PHASES);
      end
      MODE_WRITE: begin
        if (in_bits) begin
          if (ph_inc >= WR_BIT_PHASES) begin
            ph_adv  = 3'd0;
            bit_adv = cur_bit + 4'd1;
          end
        end else begin
          fin = (ph_inc >= WR_ACK_PHASES);
        end
      end
      MODE_READ: begin
        if (in_bits) begin
          if (ph_inc >= RD_BIT_PHASES) begin
            ph_adv  = 3'd0;
            bit_adv = cur_bit + 4'd1;
          end
        end else begin
          fin = (ph_inc >= RD_ACK_PHASES);
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_nxt  = cur_mode;
    phase_nxt = cur_phase;
    bit_nxt   = cur_bit;
    tick_nxt  = cur_tick;
    if (active) begin
      tick_nxt = phase_end ? 8'd0 : tick_inc;
      if (phase_end) begin
        if (fin) begin
          mode_nxt  = MODE_IDLE;
          phase_nxt = 3'd0;
          bit_nxt   = 4'd0;
        end else begin
          phase_nxt = ph_adv;
          bit_nxt   = bit_adv;
        end
      end
    end
  end

  // line changes on the first tick of a phase
  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    shift_nxt = cur_shift;
    last_nxt  = last_r;
    if (active && cur_tick == 8'd0) begin
      unique case (cur_mode)
        MODE_START: begin
          if (cur_phase == 3'd1)      sda_nxt = 1'b1;
          else if (cur_phase == 3'd2) scl_nxt = 1'b1;
          else if (cur_phase == 3'd3) sda_nxt = 1'b0;
          else if (cur_phase == 3'd4) scl_nxt = 1'b0;
        end
        MODE_STOP: begin
          if (cur_phase == 3'd1)      scl_nxt = 1'b0;
          else if (cur_phase == 3'd2) sda_nxt = 1'b0;
          else if (cur_phase == 3'd3) scl_nxt = 1'b1;
          else if (cur_phase == 3'd4) sda_nxt = 1'b1;
        end
        MODE_WRITE: begin
          if (in_bits) begin
            if (cur_phase == 3'd0) begin
              sda_nxt = cur_shift[7];
            end else if (cur_phase == 3'd1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt   = 1'b0;
              shift_nxt = {cur_shift[6:0], 1'b0};
            end
          end else if (cur_phase == 3'd0) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else begin
            ack_nxt = q_item.sda_in;
            scl_nxt = 1'b0;
          end
        end
        MODE_READ: begin
          if (in_bits) begin
            if (cur_phase == 3'd0) begin
              sda_nxt = 1'b1;
              scl_nxt = 1'b1;
            end else begin
              shift_nxt = {cur_shift[6:0], q_item.sda_in};
              scl_nxt   = 1'b0;
            end
          end else if (cur_phase == 3'd0) begin
            sda_nxt = cur_nack;
            scl_nxt = 1'b1;
          end else if (cur_phase == 3'd1) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt  = 1'b1;
            last_nxt = cur_shift;
          end
        end
        default: begin
          scl_nxt = scl_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_len_r <= 8'd1;
    end else if (cfg_we) begin
      phase_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      phase_r     <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      tick_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      nack_r      <= 1'b0;
      last_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (step) begin
        mode_r  <= mode_nxt;
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        tick_r  <= tick_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        nack_r  <= cur_nack;
        last_r  <= last_nxt;
      end
      if (step) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r.scl_level  <= scl_nxt;
      res_r.sda_level  <= sda_nxt;
      res_r.busy_res   <= active;
      res_r.done_res   <= done;
      res_r.rd_byte    <= last_nxt;
      res_r.ack_status <= ack_nxt;
    end
  end

endmodule
`default_nettype wire

[src/i2c_master_byte_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master byte engine driven by one tick beat per bus timebase tick.
// ----------------------------------------------------------------------------
// Each input beat is one tick carrying a command (taken only when idle), the
// byte to write, the ACK/NACK choice for a read and the sampled SDA level; each
// tick yields exactly one result beat with the SCL/SDA drive, busy, done, the
// last read byte and the slave ACK status. One beat is accepted and one result
// produced per clock while out_tready does not hold the output back; each tick
// goes through a two-entry tick queue and the engine's registered state update
// on its way to its result. cfg_we writes phase_len, the ticks per bus phase
// (0 acts as 1).
module i2c_master_byte_engine (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // wr_byte[7:0], send_nack, sda_in, zero fill
  input  wire logic [2:0]   in_tuser,   // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata   // scl_level, sda_level, busy_res, done_res,
                                        // rd_byte[7:0], ack_status, zero fill
);
  import i2cm_pkg::*;

  logic        q_push, q_full, q_pop, q_nonempty;
  tick_item_t  q_in, q_head;
  result_t     res;

  i2cm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_item    (q_in),
    .q_full    (q_full)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head_item (q_head)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_nonempty (q_nonempty),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {3'b000, res};

endmodule
`default_nettype wire
